>>> src/uart_tx_ring_hex_expander_macros.svh
// Assertion macros shared by the transmit ring buffer RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef UART_TX_RING_HEX_EXPANDER_MACROS_SVH
`define UART_TX_RING_HEX_EXPANDER_MACROS_SVH

// Same-cycle implication.
`define UTHX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UTHX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/uthx_pkg.sv
// Package for the transmit ring buffer: default depth, entry widths, sequencer codes, request kinds, hex digits.
// No dependencies.
package uthx_pkg;

   localparam int DEFAULT_DEPTH = 512;

   localparam int ENTRY_W = 9;   // raw flag in bit 8, byte below
   localparam int BYTE_W  = 8;

   // sequencer codes
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   // request kinds
   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_READY = 1'b1;

   localparam logic [7:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return HEX_DIGITS[nib];
   endfunction

endpackage

>>> src/uthx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module uthx_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/uart_tx_ring_hex_expander.sv
// Top level of the serial transmit ring buffer with hex expansion.
// Depends on uthx_pkg, uthx_ram and uart_tx_ring_hex_expander_macros.svh.
//
//  Channel   | Ports                                        | Handshake
//  ----------+----------------------------------------------+---------------------------
//  request   | req_action, req_data_byte, req_is_raw,       | taken when start & !busy
//            | req_end_of_string                            |
//  response  | rsp_tx_valid, rsp_tx_char, rsp_busy_res,     | rsp_strobe, one cycle,
//            | rsp_overflow                                 | cannot be held off
//  config    | csr_wr_en, csr_wr_data (hex_mode)            | written when csr_wr_en
//
// Cycles: a push, or a ready with nothing committed, answers on the cycle after
// the request and busy stays low, so one request a cycle. A ready that finds a
// committed byte reads the ring memory through its registered read port: busy is high
// for one cycle and the response is registered from that read data in ST_READ.
// Reset: synchronous, active high; resets the pointers, nibble flag, hex_mode, state and strobe.
// The ring memory is not cleared; only written entries are ever read.
// The receiver cannot stall: each response is shown for exactly one cycle.
module uart_tx_ring_hex_expander #(
   parameter int DEPTH = uthx_pkg::DEFAULT_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // request
   input  logic       start,
   output logic       busy,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_raw,
   input  logic       req_end_of_string,
   // response
   output logic       rsp_strobe,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_char,
   output logic       rsp_busy_res,
   output logic       rsp_overflow,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   import uthx_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + AW'(1);
   endfunction

   // pointers: last sent, end of committed string, end of pushed bytes
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] committed_ff, committed_in;
   logic [AW-1:0] pending_ff, pending_in;
   logic          low_nib_ff, low_nib_in;
   logic          hex_mode_ff;
   logic          state_ff, state_in;

   // response registers
   logic          strobe_ff, strobe_in;
   logic          tx_valid_ff, tx_valid_in;
   logic [7:0]    tx_char_ff, tx_char_in;
   logic          busy_res_ff, busy_res_in;
   logic          overflow_ff, overflow_in;

   // ring memory access
   logic                 accept;
   logic                 full;
   logic                 have_data;
   logic                 wr_en;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        push_slot;
   logic [ENTRY_W-1:0]   rd_data;
   logic [BYTE_W-1:0]    entry_byte;
   logic                 entry_raw;

   assign busy      = (state_ff == ST_READ);
   assign accept    = start && !busy;
   assign push_slot = ring_next(pending_ff);
   assign full      = (push_slot == last_ff);   // DEPTH-1 bytes pending
   assign have_data = (committed_ff != last_ff);
   assign rd_addr   = ring_next(last_ff);
   assign wr_en     = accept && (req_action == ACT_PUSH) && !full;
   assign rd_en     = accept && (req_action == ACT_READY) && have_data;

   assign entry_byte = rd_data[BYTE_W-1:0];
   assign entry_raw  = rd_data[ENTRY_W-1];

   uthx_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (push_slot),
      .wr_data ({req_is_raw, req_data_byte}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      last_in      = last_ff;
      committed_in = committed_ff;
      pending_in   = pending_ff;
      low_nib_in   = low_nib_ff;
      state_in     = state_ff;
      strobe_in    = 1'b0;
      tx_valid_in  = 1'b0;
      tx_char_in   = '0;
      busy_res_in  = have_data;
      overflow_in  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_PUSH) begin
                  strobe_in = 1'b1;
                  if (full) begin
                     overflow_in = 1'b1;
                  end else begin
                     pending_in = push_slot;
                  end
                  if (req_end_of_string) begin
                     committed_in = pending_in;
                  end
                  busy_res_in = (committed_in != last_ff);
               end else if (have_data) begin
                  // wait in ST_READ for the ring read
                  state_in = ST_READ;
               end else begin
                  strobe_in   = 1'b1;
                  busy_res_in = 1'b0;
               end
            end
         end
         ST_READ: begin
            state_in    = ST_IDLE;
            strobe_in   = 1'b1;
            tx_valid_in = 1'b1;
            if (hex_mode_ff && !entry_raw) begin
               if (!low_nib_ff) begin
                  tx_char_in = hex_char(entry_byte[7:4]);
                  low_nib_in = 1'b1;
               end else begin
                  tx_char_in = hex_char(entry_byte[3:0]);
                  low_nib_in = 1'b0;
                  last_in    = rd_addr;
               end
            end else begin
               tx_char_in = entry_byte;
               low_nib_in = 1'b0;
               last_in    = rd_addr;
            end
            busy_res_in = (committed_ff != last_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= LAST_IDX;
         committed_ff <= LAST_IDX;
         pending_ff   <= LAST_IDX;
         low_nib_ff   <= 1'b0;
         hex_mode_ff  <= 1'b0;
         state_ff     <= ST_IDLE;
         strobe_ff    <= 1'b0;
      end else begin
         last_ff      <= last_in;
         committed_ff <= committed_in;
         pending_ff   <= pending_in;
         low_nib_ff   <= low_nib_in;
         state_ff     <= state_in;
         strobe_ff    <= strobe_in;
         if (csr_wr_en) begin
            hex_mode_ff <= csr_wr_data;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      tx_valid_ff <= tx_valid_in;
      tx_char_ff  <= tx_char_in;
      busy_res_ff <= busy_res_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_tx_valid = tx_valid_ff;
   assign rsp_tx_char  = tx_char_ff;
   assign rsp_busy_res = busy_res_ff;
   assign rsp_overflow = overflow_ff;

`include "uart_tx_ring_hex_expander_macros.svh"

   // a ring read always completes on the next cycle with a character
   `UTHX_ASSERT_NEXT(a_read_completes, state_ff == ST_READ,
      strobe_ff && tx_valid_ff && state_ff == ST_IDLE, "ring read did not complete")
   // a read is only ever in flight for committed data
   `UTHX_ASSERT_NOW(a_read_has_data, state_ff == ST_READ,
      committed_ff != last_ff, "ring read with nothing committed")
   // a character and an overflow never come together
   `UTHX_ASSERT_NOW(a_valid_no_ovf, strobe_ff && tx_valid_ff,
      !overflow_ff, "overflow flagged on a transmit")
   // a dropped push leaves the pending end where it was
   `UTHX_ASSERT_NEXT(a_full_holds, accept && req_action == ACT_PUSH && full,
      pending_ff == $past(pending_ff), "full ring moved pending end")

endmodule

>>> sim/tx_ring_checker.sv
// Checker for the serial transmit ring buffer: keeps its own copy of the ring,
// pointers and hex_mode, predicts each response and compares it. Needs uthx_pkg.
module tx_ring_checker #(
   parameter int DEPTH = uthx_pkg::DEFAULT_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_raw,
   input  logic       req_end_of_string,
   input  logic       rsp_strobe,
   input  logic       rsp_tx_valid,
   input  logic [7:0] rsp_tx_char,
   input  logic       rsp_busy_res,
   input  logic       rsp_overflow,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         mismatches,
   output int         awaited
);
   timeunit 1ns;
   timeprecision 1ps;
   import uthx_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_char;
      logic       busy_res;
      logic       overflow;
   } tx_result_type;

   logic [ENTRY_W-1:0] ring [DEPTH];
   logic [IDX_W-1:0]   sent_idx, commit_idx, pend_idx;
   logic               low_nib;
   logic               hex_mode;
   tx_result_type      tx_expected [$];

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (int'(i) == DEPTH - 1) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [7:0] ascii_nibble(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
   endfunction

   // advances the ring copy by one request and returns the response it causes
   function automatic tx_result_type predict_char(input logic act, input logic [7:0] data,
                                                  input logic raw, input logic eos);
      tx_result_type      r;
      int                 queued;
      logic [IDX_W-1:0]   slot;
      logic [ENTRY_W-1:0] entry;
      r = '0;
      if (act == ACT_PUSH) begin
         queued = (pend_idx >= sent_idx) ? int'(pend_idx) - int'(sent_idx)
                                         : int'(pend_idx) + DEPTH - int'(sent_idx);
         if (queued >= DEPTH - 1) begin
            r.overflow = 1'b1;
         end else begin
            slot       = next_slot(pend_idx);
            ring[slot] = {raw, data};
            pend_idx   = slot;
         end
         if (eos) commit_idx = pend_idx;
      end else if (commit_idx != sent_idx) begin
         slot       = next_slot(sent_idx);
         entry      = ring[slot];
         r.tx_valid = 1'b1;
         if (hex_mode && !entry[8]) begin
            if (!low_nib) begin
               r.tx_char = ascii_nibble(entry[7:4]);
               low_nib   = 1'b1;
            end else begin
               r.tx_char = ascii_nibble(entry[3:0]);
               low_nib   = 1'b0;
               sent_idx  = slot;
            end
         end else begin
            r.tx_char = entry[7:0];
            low_nib   = 1'b0;
            sent_idx  = slot;
         end
      end
      r.busy_res = (commit_idx != sent_idx);
      return r;
   endfunction

   initial begin
      mismatches = 0;
      awaited    = 0;
   end

   always @(posedge clock) begin : watch
      tx_result_type got, want;
      if (reset) begin
         sent_idx   = IDX_W'(DEPTH - 1);
         commit_idx = IDX_W'(DEPTH - 1);
         pend_idx   = IDX_W'(DEPTH - 1);
         low_nib    = 1'b0;
         hex_mode   = 1'b0;
         tx_expected.delete();
      end else begin
         if (rsp_strobe) begin
            got = {rsp_tx_valid, rsp_tx_char, rsp_busy_res, rsp_overflow};
            if (tx_expected.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response with none awaited: valid %b char %h busy %b ovf %b",
                           $realtime, got.tx_valid, got.tx_char, got.busy_res, got.overflow);
               mismatches++;
            end else begin
               want = tx_expected.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("%0t: exp/act valid %b/%b char %h/%h busy %b/%b ovf %b/%b",
                              $realtime, want.tx_valid, got.tx_valid, want.tx_char,
                              got.tx_char, want.busy_res, got.busy_res, want.overflow,
                              got.overflow);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) hex_mode = csr_wr_data;
         if (start && !busy)
            tx_expected.push_back(predict_char(req_action, req_data_byte, req_is_raw,
                                               req_end_of_string));
      end
      awaited = tx_expected.size();
   end

endmodule

>>> sim/testbench.sv
// Top of the transmit ring buffer test: clock, reset, request stimulus and verdict.
// Depends on uthx_pkg, uart_tx_ring_hex_expander and tx_ring_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import uthx_pkg::*;

   localparam logic HEX_OFF = 1'b0;
   localparam logic HEX_ON  = 1'b1;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_action;
   logic [7:0] req_data_byte;
   logic       req_is_raw;
   logic       req_end_of_string;
   logic       rsp_strobe;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_char;
   logic       rsp_busy_res;
   logic       rsp_overflow;
   logic       csr_wr_en;
   logic       csr_wr_data;
   int         mismatches;
   int         awaited;

   // burst bookkeeping for the request side, requests sent, and our view of hex_mode
   int         burst_left;
   int         sent_items;
   logic       hex_now;

   uart_tx_ring_hex_expander u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_is_raw        (req_is_raw),
      .req_end_of_string (req_end_of_string),
      .rsp_strobe        (rsp_strobe),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_char       (rsp_tx_char),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   tx_ring_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_is_raw        (req_is_raw),
      .req_end_of_string (req_end_of_string),
      .rsp_strobe        (rsp_strobe),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_char       (rsp_tx_char),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatches        (mismatches),
      .awaited           (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run (some eight hundred requests,
   // each at worst a ring read plus a random sender gap).
   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

   // One request. Inputs move on the falling edge; the request is taken at the
   // first rising edge with busy low. Between bursts start drops for a random
   // gap, so gaps land on every phase of a ring read. start is left high on
   // return, so back-to-back requests keep it high without a glitch.
   task automatic send_request(input logic act, input logic [7:0] data,
                               input logic raw, input logic eos);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         // mostly short bursts, now and then a long run with no idling
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      sent_items++;
      @(negedge clock);
      start             <= 1'b1;
      req_action        <= act;
      req_data_byte     <= data;
      req_is_raw        <= raw;
      req_end_of_string <= eos;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Ready requests only; the other fields get random junk, which the block ignores.
   task automatic send_readies(input int n);
      repeat (n) send_request(ACT_READY, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // hex_mode is only written with nothing in flight. Every request answers, so
   // an empty checker queue means idle; the extra wait covers the ring read.
   task automatic set_hex_mode(input logic v);
      @(negedge clock) start <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock) csr_wr_en <= 1'b0;
      hex_now = v;
   endtask

   initial begin : stimulus
      int   n, need, k, i;
      logic raw, eos, act;

      reset             = 1'b1;
      start             = 1'b0;
      req_action        = ACT_PUSH;
      req_data_byte     = '0;
      req_is_raw        = 1'b0;
      req_end_of_string = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 1'b0;
      burst_left        = 0;
      sent_items        = 0;
      hex_now           = HEX_OFF;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // plain mode after reset; ready with nothing committed
      send_readies(1);
      // a push without end of string stays invisible to the transmitter
      send_request(ACT_PUSH, 8'h00, 1'b0, 1'b0);
      send_readies(1);
      // end of string commits both bytes; the third ready finds nothing
      send_request(ACT_PUSH, 8'hFF, 1'b1, 1'b1);
      send_readies(3);

      // hex mode: non-raw bytes split high nibble first, raw byte unchanged
      set_hex_mode(HEX_ON);
      send_request(ACT_PUSH, 8'hA5, 1'b0, 1'b0);
      send_request(ACT_PUSH, 8'h3C, 1'b1, 1'b0);
      send_request(ACT_PUSH, 8'hFF, 1'b0, 1'b0);
      send_request(ACT_PUSH, 8'h00, 1'b0, 1'b1);
      send_readies(8);

      // hex mode switched off half way through a byte: the whole byte then goes out
      send_request(ACT_PUSH, 8'h7E, 1'b0, 1'b1);
      send_readies(1);
      set_hex_mode(HEX_OFF);
      send_readies(2);

      // and switched on again: the next hex byte still starts high
      send_request(ACT_PUSH, 8'h9B, 1'b0, 1'b1);
      set_hex_mode(HEX_ON);
      send_readies(3);

      // --- full ring ---
      // Fill to DEPTH-1 pending bytes without committing, poke a ready at the
      // uncommitted pile, then push past the limit: both extra pushes are
      // dropped, and the second one's end of string still commits the lot.
      for (i = 0; i < DEFAULT_DEPTH - 1; i++)
         send_request(ACT_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      send_readies(1);
      send_request(ACT_PUSH, 8'h55, 1'b0, 1'b0);
      send_request(ACT_PUSH, 8'hAA, 1'b1, 1'b1);
      send_readies(4);

      // --- random part ---
      // Mostly whole strings with random content followed by roughly enough
      // readies to drain them, sometimes too few so a backlog builds up;
      // the rest is loose noise. It starts against the nearly full ring left
      // above, so early pushes overflow until readies make room.
      while (sent_items < 800) begin
         if ($urandom_range(0, 5) == 0) set_hex_mode(1'($urandom_range(0, 1)));
         if ($urandom_range(0, 4) != 0) begin
            n    = $urandom_range(1, 10);
            need = 0;
            for (i = 0; i < n; i++) begin
               raw = 1'($urandom_range(0, 1));
               eos = (i == n - 1) || ($urandom_range(0, 7) == 0);
               send_request(ACT_PUSH, 8'($urandom_range(0, 255)), raw, eos);
               need += (hex_now && !raw) ? 2 : 1;
            end
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, need)
                                            : $urandom_range(need, need + 3);
            send_readies(k);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               act = 1'($urandom_range(0, 1));
               send_request(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end
         end
      end

      // --- wind down ---
      @(negedge clock) start <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
